@@ hw/rtl/flptw_pkg.sv @@
`default_nettype none

package flptw_pkg;

  localparam int TABLE_PAGES       = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int WALK_LEVELS       = 4;

  localparam int IDX_W     = $clog2(ENTRIES_PER_TABLE);
  localparam int LEVEL_W   = $clog2(WALK_LEVELS);
  localparam int VA_W      = 64;
  localparam int PA_W      = 52;
  localparam int ENTRY_W   = 64;
  localparam int FLAG_W    = 12;
  localparam int FRAME_W   = PA_W - FLAG_W;
  localparam int PS_BIT    = 7;
  localparam int CANON_BIT = 47;

  // config port: 64-bit registers at 8-byte stride
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 64;
  localparam int REG_SHIFT = 3;

  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_IFLAGS = 1'b1;

  localparam logic [FLAG_W-1:0] IFLAGS_RESET = 12'h003;

  localparam logic MODE_MAP    = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_MAPPED = 3'd1;
  localparam logic [2:0] ST_NO_FREE    = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR   = 3'd3;
  localparam logic [2:0] ST_BAD_PTR    = 3'd4;

  localparam logic [1:0] SZ_4K   = 2'd0;
  localparam logic [1:0] SZ_2M   = 2'd1;
  localparam logic [1:0] SZ_1G   = 2'd2;
  localparam logic [1:0] SZ_512G = 2'd3;

  // how the walk ended
  localparam logic [2:0] FIN_BAD        = 3'd0;
  localparam logic [2:0] FIN_NO_FREE    = 3'd1;
  localparam logic [2:0] FIN_BAD_PTR    = 3'd2;
  localparam logic [2:0] FIN_NOT_MAPPED = 3'd3;
  localparam logic [2:0] FIN_FOUND      = 3'd4;
  localparam logic [2:0] FIN_LEAF       = 3'd5;

  typedef struct packed {
    logic       load;
    logic       clr_wr;
    logic       rd;
    logic       alloc;
    logic       step;
    logic       leaf_wr;
    logic       fin;
    logic [2:0] fin_code;
    logic       emit;
  } flptw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad;
    logic lookup;
    logic e_zero;
    logic present;
    logic final_hit;
    logic follow_ok;
    logic pool_empty;
    logic next_leaf;
    logic out_free;
  } flptw_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/flptw_if.sv @@
`default_nettype none

interface flptw_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] virt_addr;
  logic [51:0] phys_addr;
  logic [1:0]  page_size;
  logic [63:0] leaf_flags;

  modport source (output valid, mode, virt_addr, phys_addr, page_size, leaf_flags,
                  input ready);
  modport sink (input valid, mode, virt_addr, phys_addr, page_size, leaf_flags,
                output ready);
endinterface

interface flptw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] entry;
  logic [1:0]  mapped_size;

  modport source (output valid, status, entry, mapped_size, input ready);
  modport sink (input valid, status, entry, mapped_size, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/four_level_page_table_walker.sv @@
`default_nettype none

// Four-level page table walker. Holds x86-64 style page tables in an internal
// store of TABLE_PAGES tables of 512 entries; table k sits at table_region_base
// + k*4 KiB and table 0 is the root. A map item (mode 0) walks 4, 3 or 2
// levels for a 4 KiB, 2 MiB or 1 GiB page, takes missing intermediate tables
// from a bump allocator, links them with intermediate_flags, and writes the
// leaf as phys_addr | leaf_flags, plus bit 7 for large pages. A lookup item
// (mode 1) returns the entry where the walk stops and the size it covers.
// One item is worked at a time: the store has one read port with registered
// read data, so each table read is followed by its own evaluate step. A bad
// address is rejected before any table is read. The next item can be taken
// in the cycle in which the result is first offered; a result still waiting
// at the output holds the walk in its last step. After reset a clearing
// pass zeroes the store, one entry per cycle, during which no item is
// accepted; register writes are taken at any time. Registers sit on the
// APB port at byte 0x0 (table_region_base, bits 51..12 kept) and 0x8
// (intermediate_flags, bits 11..0), and should be written only while idle.

module four_level_page_table_walker #(
  parameter int TABLE_PAGES = flptw_pkg::TABLE_PAGES
) (
  input  logic                           clk,
  input  logic                           rst,
  flptw_in_if.sink                       request,
  flptw_out_if.source                    response,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [flptw_pkg::CFG_AW-1:0]   paddr,
  input  logic [flptw_pkg::CFG_DW-1:0]   pwdata,
  output logic [flptw_pkg::CFG_DW-1:0]   prdata,
  output logic                           pready
);

  // config registers; base is kept as a frame number (always 4 KiB aligned)
  logic [flptw_pkg::FRAME_W-1:0] base_frame;
  logic [flptw_pkg::FLAG_W-1:0]  iflags;

  flptw_pkg::flptw_cmd_t  cmd;
  flptw_pkg::flptw_stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame <= '0;
      iflags     <= flptw_pkg::IFLAGS_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[flptw_pkg::REG_SHIFT])
        flptw_pkg::REG_BASE:   base_frame <= pwdata[flptw_pkg::PA_W-1:flptw_pkg::FLAG_W];
        flptw_pkg::REG_IFLAGS: iflags     <= pwdata[flptw_pkg::FLAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[flptw_pkg::REG_SHIFT])
      flptw_pkg::REG_BASE: begin
        prdata = {{(flptw_pkg::CFG_DW - flptw_pkg::PA_W){1'b0}}, base_frame,
                  {flptw_pkg::FLAG_W{1'b0}}};
      end
      flptw_pkg::REG_IFLAGS: begin
        prdata = {{(flptw_pkg::CFG_DW - flptw_pkg::FLAG_W){1'b0}}, iflags};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // sequencer: clearing pass, then one walk at a time
  flptw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table store, walk registers, allocator and result registers
  flptw_dp #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (request.mode),
    .in_virt_addr    (request.virt_addr),
    .in_phys_addr    (request.phys_addr),
    .in_page_size    (request.page_size),
    .in_leaf_flags   (request.leaf_flags),
    .base_frame      (base_frame),
    .iflags          (iflags),
    .out_ready       (response.ready),
    .out_valid       (response.valid),
    .out_status      (response.status),
    .out_entry       (response.entry),
    .out_mapped_size (response.mapped_size)
  );

endmodule

`default_nettype wire

@@ hw/rtl/flptw_ctrl.sv @@
`default_nettype none

module flptw_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  flptw_pkg::flptw_stat_t  stat,
  output flptw_pkg::flptw_cmd_t   cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_LEAF  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad) begin
          cmd.fin      = 1'b1;
          cmd.fin_code = flptw_pkg::FIN_BAD;
          state_next   = S_FIN;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.lookup) begin
          if (stat.e_zero && stat.pool_empty) begin
            cmd.fin      = 1'b1;
            cmd.fin_code = flptw_pkg::FIN_NO_FREE;
            state_next   = S_FIN;
          end else begin
            // a new table is linked even if it then falls outside the region
            cmd.alloc = stat.e_zero;
            if (!stat.follow_ok) begin
              cmd.fin      = 1'b1;
              cmd.fin_code = flptw_pkg::FIN_BAD_PTR;
              state_next   = S_FIN;
            end else begin
              cmd.step   = 1'b1;
              state_next = stat.next_leaf ? S_LEAF : S_READ;
            end
          end
        end else if (!stat.present) begin
          cmd.fin      = 1'b1;
          cmd.fin_code = flptw_pkg::FIN_NOT_MAPPED;
          state_next   = S_FIN;
        end else if (stat.final_hit) begin
          cmd.fin      = 1'b1;
          cmd.fin_code = flptw_pkg::FIN_FOUND;
          state_next   = S_FIN;
        end else if (!stat.follow_ok) begin
          cmd.fin      = 1'b1;
          cmd.fin_code = flptw_pkg::FIN_BAD_PTR;
          state_next   = S_FIN;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_READ;
        end
      end
      S_LEAF: begin
        cmd.leaf_wr  = 1'b1;
        cmd.fin      = 1'b1;
        cmd.fin_code = flptw_pkg::FIN_LEAF;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/flptw_dp.sv @@
`default_nettype none

module flptw_dp #(
  parameter int TABLE_PAGES = flptw_pkg::TABLE_PAGES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  flptw_pkg::flptw_cmd_t             cmd,
  output flptw_pkg::flptw_stat_t            stat,
  input  logic                              in_mode,
  input  logic [flptw_pkg::VA_W-1:0]        in_virt_addr,
  input  logic [flptw_pkg::PA_W-1:0]        in_phys_addr,
  input  logic [1:0]                        in_page_size,
  input  logic [flptw_pkg::ENTRY_W-1:0]     in_leaf_flags,
  input  logic [flptw_pkg::FRAME_W-1:0]     base_frame,
  input  logic [flptw_pkg::FLAG_W-1:0]      iflags,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [flptw_pkg::ENTRY_W-1:0]     out_entry,
  output logic [1:0]                        out_mapped_size
);

  localparam int TW    = $clog2(TABLE_PAGES);
  localparam int NW    = $clog2(TABLE_PAGES + 1);
  localparam int IW    = flptw_pkg::IDX_W;
  localparam int LW    = flptw_pkg::LEVEL_W;
  localparam int AW    = TW + IW;
  localparam int DEPTH = TABLE_PAGES * flptw_pkg::ENTRIES_PER_TABLE;
  localparam int EW    = flptw_pkg::ENTRY_W;
  localparam int FW    = flptw_pkg::FRAME_W;
  localparam int GW    = flptw_pkg::FLAG_W;

  // entry word plus a stamp: set when the entry was written after its table was allocated
  logic [EW:0] mem [DEPTH];

  logic              mode;
  logic [63:0]       va;
  logic [51:0]       pa;
  logic [1:0]        ps;
  logic [EW-1:0]     lflags;
  logic [LW-1:0]     level;
  logic [TW-1:0]     tbl;
  logic [NW-1:0]     nf;
  logic [AW-1:0]     clr_addr;
  logic [EW:0]       rdata;
  logic [2:0]        res_status;
  logic [EW-1:0]     res_entry;
  logic [1:0]        res_size;

  logic              canon;
  logic              misalign;
  logic [IW-1:0]     idx;
  logic [AW-1:0]     slot;
  logic [NW-1:0]     nf_inc;
  logic              tbl_alloc;
  logic              tbl_alloc_next;
  logic [EW-1:0]     e;
  logic [FW-1:0]     new_frame;
  logic [EW-1:0]     new_e;
  logic [EW-1:0]     cand;
  logic [FW-1:0]     diff;
  logic              follow_ok;
  logic [EW-1:0]     leaf_val;
  logic [1:0]        level_size;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [EW:0]       wdata;

  assign canon = (va[63:flptw_pkg::CANON_BIT] == '0) || (va[63:flptw_pkg::CANON_BIT] == '1);

  always_comb begin
    case (ps)
      flptw_pkg::SZ_4K: misalign = (|va[11:0]) || (|pa[11:0]);
      flptw_pkg::SZ_2M: misalign = (|va[20:0]) || (|pa[20:0]);
      flptw_pkg::SZ_1G: misalign = (|va[29:0]) || (|pa[29:0]);
      default:          misalign = 1'b0;
    endcase
  end

  always_comb begin
    case (level)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
  end

  assign slot           = {tbl, idx};
  assign nf_inc         = nf + NW'(1);
  assign tbl_alloc      = NW'(tbl) < nf;
  assign tbl_alloc_next = NW'(tbl) < nf_inc;

  // an entry stamped before its table was allocated was wiped by the allocation
  assign e = (tbl_alloc && !rdata[EW]) ? '0 : rdata[EW-1:0];

  assign new_frame = base_frame + FW'(nf);
  assign new_e     = {{(EW - flptw_pkg::PA_W){1'b0}}, new_frame, iflags};
  assign cand      = (e == '0) ? new_e : e;
  assign diff      = cand[flptw_pkg::PA_W-1:GW] - base_frame;
  assign follow_ok = (cand[flptw_pkg::PA_W-1:GW] >= base_frame) && (diff < FW'(TABLE_PAGES));

  assign leaf_val = {{(EW - flptw_pkg::PA_W){1'b0}}, pa} | lflags |
                    ((ps != flptw_pkg::SZ_4K) ? (EW'(1) << flptw_pkg::PS_BIT) : '0);

  assign level_size = 2'(flptw_pkg::WALK_LEVELS - 1) - level;

  assign stat.clr_last   = (clr_addr == AW'(DEPTH - 1));
  assign stat.bad        = !canon ||
                           ((mode == flptw_pkg::MODE_MAP) && ((ps == 2'd3) || misalign));
  assign stat.lookup     = (mode == flptw_pkg::MODE_LOOKUP);
  assign stat.e_zero     = (e == '0);
  assign stat.present    = e[0];
  assign stat.final_hit  = (level == LW'(flptw_pkg::WALK_LEVELS - 1)) ||
                           (((level == 2'd1) || (level == 2'd2)) && e[flptw_pkg::PS_BIT]);
  assign stat.follow_ok  = follow_ok;
  assign stat.pool_empty = (nf >= NW'(TABLE_PAGES));
  assign stat.next_leaf  = (level == (LW'(flptw_pkg::WALK_LEVELS - 2) - ps));
  assign stat.out_free   = !out_valid || out_ready;

  assign we    = cmd.clr_wr || cmd.alloc || cmd.leaf_wr;
  assign waddr = cmd.clr_wr ? clr_addr : slot;

  always_comb begin
    if (cmd.clr_wr) begin
      wdata = '0;
    end else if (cmd.alloc) begin
      wdata = {tbl_alloc_next, new_e};
    end else begin
      wdata = {tbl_alloc, leaf_val};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nf        <= NW'(1);
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.alloc) begin
        nf <= nf_inc;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode   <= in_mode;
      va     <= in_virt_addr;
      pa     <= in_phys_addr;
      ps     <= in_page_size;
      lflags <= in_leaf_flags;
      level  <= '0;
      tbl    <= '0;
    end else if (cmd.step) begin
      level <= level + LW'(1);
      tbl   <= diff[TW-1:0];
    end
    if (cmd.fin) begin
      case (cmd.fin_code)
        flptw_pkg::FIN_NO_FREE: begin
          res_status <= flptw_pkg::ST_NO_FREE;
          res_entry  <= '0;
          res_size   <= level_size;
        end
        flptw_pkg::FIN_BAD_PTR: begin
          res_status <= flptw_pkg::ST_BAD_PTR;
          res_entry  <= (mode == flptw_pkg::MODE_LOOKUP) ? e : '0;
          res_size   <= level_size;
        end
        flptw_pkg::FIN_NOT_MAPPED: begin
          res_status <= flptw_pkg::ST_NOT_MAPPED;
          res_entry  <= e;
          res_size   <= level_size;
        end
        flptw_pkg::FIN_FOUND: begin
          res_status <= flptw_pkg::ST_OK;
          res_entry  <= e;
          res_size   <= level_size;
        end
        flptw_pkg::FIN_LEAF: begin
          res_status <= flptw_pkg::ST_OK;
          res_entry  <= leaf_val;
          res_size   <= ps;
        end
        default: begin
          res_status <= flptw_pkg::ST_BAD_ADDR;
          res_entry  <= '0;
          res_size   <= flptw_pkg::SZ_512G;
        end
      endcase
    end
    if (cmd.emit) begin
      out_status      <= res_status;
      out_entry       <= res_entry;
      out_mapped_size <= res_size;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/flptw_checker.sv @@
`default_nettype none

module flptw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [63:0] out_entry,
  input logic [1:0]  out_mapped_size
);

  // status stays within its defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status <= flptw_pkg::ST_BAD_PTR))
    else $error("status code out of range");

  // a rejected address carries no entry and the widest size
  a_bad_addr_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == flptw_pkg::ST_BAD_ADDR) |->
      (out_entry == 64'd0 && out_mapped_size == flptw_pkg::SZ_512G))
    else $error("bad address result malformed");

  // a good large-page result always has the page-size bit set
  a_large_ps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == flptw_pkg::ST_OK &&
     (out_mapped_size == flptw_pkg::SZ_2M || out_mapped_size == flptw_pkg::SZ_1G)) |->
      out_entry[flptw_pkg::PS_BIT])
    else $error("large page without page-size bit");

  // one walk at a time: no back-to-back accept
  a_one_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while walk in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_entry) && $stable(out_status) && $stable(out_mapped_size)))
    else $error("stalled result changed");

endmodule

bind four_level_page_table_walker flptw_checker u_flptw_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (request.valid),
  .in_ready        (request.ready),
  .out_valid       (response.valid),
  .out_ready       (response.ready),
  .out_status      (response.status),
  .out_entry       (response.entry),
  .out_mapped_size (response.mapped_size)
);

`default_nettype wire

@@ bench/walk_checker.sv @@
`timescale 1ns / 1ps

// Watches the request, response and register channels of the walker, keeps
// its own copy of the page table store, and checks every result in order.
module walk_checker
  import flptw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  flptw_in_if               req,
  flptw_out_if              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                errors,
  output int                walks_in_flight,
  output int                status_tally [5]
);

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] entry;
    logic [1:0]  mapped_size;
  } walk_result_t;

  localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam logic [63:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] PA_MASK    = 64'h000F_FFFF_FFFF_FFFF;

  logic [63:0]       page_store [STORE_DEPTH];
  int unsigned       next_table;
  logic [63:0]       region_base;
  logic [FLAG_W-1:0] link_flags;
  walk_result_t      expected_walks [$];

  function automatic int unsigned slot_of(input int unsigned tbl, input logic [63:0] va,
                                          input int lvl);
    logic [63:0] idx;
    idx = (va >> (39 - 9 * lvl)) & 64'(ENTRIES_PER_TABLE - 1);
    return tbl * ENTRIES_PER_TABLE + int'(idx);
  endfunction

  // pointer -> table number; returns 0 when the frame lies outside the region
  function automatic bit table_of(input logic [63:0] e, output int unsigned tbl);
    logic [63:0] frame;
    logic [63:0] off;
    frame = e & FRAME_MASK;
    if (frame < region_base) return 1'b0;
    off = (frame - region_base) >> 12;
    if (off >= 64'(TABLE_PAGES)) return 1'b0;
    tbl = int'(off);
    return 1'b1;
  endfunction

  function automatic walk_result_t walk_tables(input logic m, input logic [63:0] va,
                                               input logic [51:0] pa, input logic [1:0] ps,
                                               input logic [63:0] fl);
    walk_result_t r;
    int unsigned  tbl;
    int unsigned  s;
    int           depth;
    int           lvl;
    logic [63:0]  e;
    logic [63:0]  v;
    logic [63:0]  amask;
    bit           done;
    tbl = 0;
    done = 1'b0;
    r = '{ST_BAD_ADDR, 64'd0, SZ_512G};
    if (!(va[63:47] == '0 || &va[63:47])) return r;
    if (m == MODE_MAP) begin
      if (ps == 2'd3) return r;
      depth = WALK_LEVELS - int'(ps);
      amask = (64'd1 << (12 + 9 * int'(ps))) - 64'd1;
      if ((va & amask) != 0 || (64'(pa) & amask) != 0) return r;
      for (lvl = 0; lvl < depth && !done; lvl++) begin
        s = slot_of(tbl, va, lvl);
        e = page_store[s];
        if (lvl == depth - 1) begin
          v = 64'(pa) | fl;
          if (ps != SZ_4K) v[PS_BIT] = 1'b1;
          page_store[s] = v;
          r = '{ST_OK, v, ps};
          done = 1'b1;
        end else begin
          if (e == 0) begin
            if (next_table >= TABLE_PAGES) begin
              r = '{ST_NO_FREE, 64'd0, 2'(3 - lvl)};
              done = 1'b1;
            end else begin
              // a fresh table may already hold writes that went through a stray pointer
              for (int i = 0; i < ENTRIES_PER_TABLE; i++)
                page_store[next_table * ENTRIES_PER_TABLE + i] = '0;
              e = ((region_base + (64'(next_table) << 12)) & PA_MASK) | 64'(link_flags);
              page_store[s] = e;
              next_table++;
            end
          end
          if (!done && !table_of(e, tbl)) begin
            r = '{ST_BAD_PTR, 64'd0, 2'(3 - lvl)};
            done = 1'b1;
          end
        end
      end
      return r;
    end
    for (lvl = 0; lvl < WALK_LEVELS && !done; lvl++) begin
      e = page_store[slot_of(tbl, va, lvl)];
      if (!e[0]) begin
        r = '{ST_NOT_MAPPED, e, 2'(3 - lvl)};
        done = 1'b1;
      end else if (lvl == WALK_LEVELS - 1 || ((lvl == 1 || lvl == 2) && e[PS_BIT])) begin
        r = '{ST_OK, e, 2'(3 - lvl)};
        done = 1'b1;
      end else if (!table_of(e, tbl)) begin
        r = '{ST_BAD_PTR, e, 2'(3 - lvl)};
        done = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    walk_result_t      want;
    logic [CFG_AW-1:0] reg_idx;
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) page_store[i] = '0;
      next_table = 1;
      region_base = '0;
      link_flags = IFLAGS_RESET;
      expected_walks.delete();
      errors = 0;
      walks_in_flight = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (rsp.valid && rsp.ready) begin
        if (expected_walks.size() == 0) begin
          errors++;
          $error("result with no item outstanding: status %0d entry %h",
                 rsp.status, rsp.entry);
        end else begin
          want = expected_walks.pop_front();
          if (rsp.status !== want.status) begin
            errors++;
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp.status);
          end
          if (rsp.entry !== want.entry) begin
            errors++;
            $error("entry mismatch: expected %h, actual %h", want.entry, rsp.entry);
          end
          if (rsp.mapped_size !== want.mapped_size) begin
            errors++;
            $error("mapped_size mismatch: expected %0d, actual %0d",
                   want.mapped_size, rsp.mapped_size);
          end
        end
        if (rsp.status <= ST_BAD_PTR) status_tally[rsp.status]++;
      end
      if (req.valid && req.ready)
        expected_walks.push_back(walk_tables(req.mode, req.virt_addr, req.phys_addr,
                                             req.page_size, req.leaf_flags));
      if (psel && penable && pwrite && pready) begin
        reg_idx = paddr >> REG_SHIFT;
        if (reg_idx == CFG_AW'(REG_BASE))
          region_base = pwdata & FRAME_MASK;
        else if (reg_idx == CFG_AW'(REG_IFLAGS))
          link_flags = pwdata[FLAG_W-1:0];
      end
      walks_in_flight = expected_walks.size();
    end
  end

endmodule

@@ bench/tb_four_level_page_table_walker.sv @@
`timescale 1ns / 1ps

// Top of the walker bench. Builds stimulus only; walk_checker predicts and
// compares. Flow:
//   reset, then wait out the store clearing pass (request ready stays low)
//   directed items: empty walks, every page size, bad addresses, overwrites
//   random phases, each under its own register setting, written while idle
//   one long receiver hold-off so the walker backs up onto its input
module tb_four_level_page_table_walker;
  import flptw_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 400;   // long receiver stall
  localparam int SETTLE_CYCLES = 30;    // > worst walk latency
  localparam int BURST_EVERY   = 50;    // items between idling redraws

  logic              clk;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  flptw_in_if  request_ch ();
  flptw_out_if response_ch ();

  int errors;
  int in_flight;
  int status_tally [5];

  // stimulus bookkeeping
  int          n_map;
  int          n_lookup;
  int          n_settings;
  int          cycle_count = 0;
  bit          source_burst;   // sender stops idling
  bit          sink_burst;     // receiver stops idling
  bit          hold_off_req;   // asks the receiver for one long stall
  logic [63:0] mapped_vas [$]; // recent map targets, reused by lookups

  four_level_page_table_walker u_top (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .response (response_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  walk_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req             (request_ch),
    .rsp             (response_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .errors          (errors),
    .walks_in_flight (in_flight),
    .status_tally    (status_tally)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // covers the clearing pass plus every item at its slowest
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // small index set so walks share tables; a few random ones spend the pool
  function automatic logic [8:0] pick_index();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 9'd0;
    if (r < 65) return 9'd511;
    if (r < 92) return 9'($urandom_range(1, 2));
    return 9'($urandom);
  endfunction

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new register setting, only once every result is back
  task automatic configure(input logic [CFG_DW-1:0] base, input logic [CFG_DW-1:0] flags);
    @(negedge clk);
    request_ch.valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    write_reg(CFG_AW'(REG_BASE) << REG_SHIFT, base);
    write_reg(CFG_AW'(REG_IFLAGS) << REG_SHIFT, flags);
    n_settings++;
  endtask

  // valid stays high across back-to-back items; lowered only for a gap
  task automatic send_item(input logic m, input logic [63:0] va, input logic [51:0] pa,
                           input logic [1:0] ps, input logic [63:0] fl);
    int gap;
    gap = source_burst ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    request_ch.valid      <= 1'b1;
    request_ch.mode       <= m;
    request_ch.virt_addr  <= va;
    request_ch.phys_addr  <= pa;
    request_ch.page_size  <= ps;
    request_ch.leaf_flags <= fl;
    do @(posedge clk); while (!request_ch.ready);
    if (m == MODE_MAP) n_map++;
    else n_lookup++;
  endtask

  task automatic random_item();
    int unsigned kind;
    int unsigned r;
    int          top_bit;
    logic        m;
    logic [1:0]  ps;
    logic [8:0]  i0;
    logic [63:0] va;
    logic [63:0] fl;
    logic [63:0] amask;
    logic [63:0] omask;
    logic [51:0] pa;
    kind = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    ps = (r < 60) ? SZ_4K : (r < 85) ? SZ_2M : SZ_1G;
    i0 = pick_index();
    // canonical: bits 63..48 copy bit 47, the top of the root index
    va = {{16{i0[8]}}, i0, pick_index(), pick_index(), pick_index(), 12'($urandom)};
    pa = 52'(rand64());
    // flags mostly low bits plus NX, mostly present; sometimes anything at all
    r = $urandom_range(0, 9);
    if (r == 0) begin
      fl = rand64();
    end else begin
      fl = 64'($urandom_range(0, 4095));
      fl[63] = 1'($urandom_range(0, 1));
      if (r > 1) fl[0] = 1'b1;
    end
    m = MODE_MAP;
    amask = (64'd1 << (12 + 9 * int'(ps))) - 64'd1;
    if (kind < 45) begin
      // well-formed map
      va = va & ~amask;
      pa = pa & ~amask[51:0];
      if (mapped_vas.size() < 256) mapped_vas.push_back(va);
      else mapped_vas[$urandom_range(0, 255)] = va;
    end else if (kind < 85) begin
      m = MODE_LOOKUP;
      if (mapped_vas.size() != 0 && $urandom_range(0, 9) < 7) begin
        omask = (64'd1 << (12 + 9 * $urandom_range(0, 2))) - 64'd1;
        va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)] | (rand64() & omask);
      end
    end else if (kind < 95) begin
      // broken map: reserved size, misaligned va or pa, or non-canonical va
      va = va & ~amask;
      pa = pa & ~amask[51:0];
      top_bit = 11 + 9 * int'(ps);
      case ($urandom_range(0, 3))
        0: ps = 2'd3;
        1: pa = pa | 52'(64'd1 << $urandom_range(0, top_bit));
        2: va = va | (64'd1 << $urandom_range(0, top_bit));
        default: va = va ^ (64'd1 << $urandom_range(47, 63));
      endcase
    end else begin
      // noise over every field
      m  = 1'($urandom_range(0, 1));
      va = rand64();
      pa = 52'(rand64());
      ps = 2'($urandom_range(0, 3));
      fl = rand64();
    end
    send_item(m, va, pa, ps, fl);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % BURST_EVERY == 0) begin
        source_burst = ($urandom_range(0, 3) == 0);
        sink_burst   = ($urandom_range(0, 3) == 0);
      end
      random_item();
    end
  endtask

  // response side: own gap per result, plus the single long hold-off
  initial begin : result_sink
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    response_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      gap = sink_burst ? 0 : $urandom_range(0, 19);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        response_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      response_ch.ready <= 1'b1;
      do @(posedge clk); while (!response_ch.valid);
    end
  end

  initial begin : stimulus
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    request_ch.valid      = 1'b0;
    request_ch.mode       = MODE_MAP;
    request_ch.virt_addr  = '0;
    request_ch.phys_addr  = '0;
    request_ch.page_size  = SZ_4K;
    request_ch.leaf_flags = '0;
    n_map        = 0;
    n_lookup     = 0;
    n_settings   = 0;
    source_burst = 1'b0;
    sink_burst   = 1'b0;
    hold_off_req = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // low base bits must be dropped; flags at their reset value
    configure(64'h0000_0000_0000_0ABC, 64'h003);

    // directed: empty store, each size, extremes, bad addresses
    send_item(MODE_LOOKUP, 64'h0, 52'h0, SZ_4K, 64'h0);
    send_item(MODE_MAP, 64'h0, 52'h0, SZ_4K, 64'h0);                // leaf of zero
    send_item(MODE_LOOKUP, 64'h0, 52'h0, SZ_4K, 64'h0);             // not present leaf
    send_item(MODE_MAP, 64'h1000, 52'hF_FFFF_FFFF_F000, SZ_4K, 64'h8000_0000_0000_0003);
    send_item(MODE_LOOKUP, 64'h1FFF, 52'h0, SZ_4K, 64'h0);
    send_item(MODE_MAP, 64'h0000_7FFF_FFE0_0000, 52'h20_0000, SZ_2M, 64'h1);
    send_item(MODE_LOOKUP, 64'h0000_7FFF_FFFF_FFFF, 52'h0, SZ_4K, 64'h0);
    send_item(MODE_MAP, 64'hFFFF_8000_0000_0000, 52'h4000_0000, SZ_1G, 64'h3);
    send_item(MODE_LOOKUP, 64'hFFFF_8000_1234_5678, 52'h0, SZ_4K, 64'h0);
    send_item(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 52'h0, SZ_4K, 64'h0);
    // non-canonical, reserved size, misaligned va / pa
    send_item(MODE_LOOKUP, 64'h0000_8000_0000_0000, 52'h0, SZ_4K, 64'h0);
    send_item(MODE_MAP, 64'h8000_0000_0000_0000, 52'h0, SZ_4K, 64'h3);
    send_item(MODE_MAP, 64'h0, 52'h0, 2'd3, 64'h3);
    send_item(MODE_MAP, 64'h1001, 52'h1000, SZ_4K, 64'h3);
    send_item(MODE_MAP, 64'h20_0000, 52'h1000, SZ_2M, 64'h3);
    send_item(MODE_MAP, 64'h20_0000, 52'h0, SZ_1G, 64'h3);
    // overwrite with every flag bit set
    send_item(MODE_MAP, 64'h0, 52'h5000, SZ_4K, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MODE_LOOKUP, 64'h0, 52'h0, SZ_4K, 64'h0);
    // large leaf over an existing table link, then a 4K map follows it out of region
    send_item(MODE_MAP, 64'h0, 52'h40_0000, SZ_2M, 64'h3);
    send_item(MODE_MAP, 64'h2000, 52'h2000, SZ_4K, 64'h3);
    send_item(MODE_LOOKUP, 64'h2000, 52'h0, SZ_4K, 64'h0);
    // large leaf whose frame is the root: a 4K map walks back into table 0
    send_item(MODE_MAP, 64'h20_0000, 52'h0, SZ_2M, 64'h1);
    send_item(MODE_MAP, 64'h20_3000, 52'h7000, SZ_4K, 64'h3);
    send_item(MODE_LOOKUP, 64'h20_3000, 52'h0, SZ_4K, 64'h0);
    send_item(MODE_LOOKUP, 64'h0000_0180_0000_0000, 52'h0, SZ_4K, 64'h0);

    // every flag bit on new links (PS set in intermediates)
    configure(64'h0, 64'hFFF);
    run_random(150);
    // links without the present bit
    configure(64'h0, 64'h000);
    run_random(150);
    // top of the physical range: new links wrap, old ones fall outside
    configure(64'h000F_FFFF_FFFF_FFFF, 64'h5A5);
    run_random(100);
    // region moved by 32 tables: old links alias onto other tables
    configure(64'h0000_0000_0002_0FFF, 64'h003);
    run_random(100);
    // back to the reset setting for the bulk, with one long receiver stall
    configure(64'h0, 64'h003);
    run_random(100);
    hold_off_req = 1'b1;
    run_random(950);

    @(negedge clk);
    request_ch.valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d items (%0d maps, %0d lookups) over %0d register settings",
             n_map + n_lookup, n_map, n_lookup, n_settings);
    $display("results: %0d ok, %0d not mapped, %0d no free table, %0d bad address, %0d bad pointer",
             status_tally[int'(ST_OK)], status_tally[int'(ST_NOT_MAPPED)],
             status_tally[int'(ST_NO_FREE)], status_tally[int'(ST_BAD_ADDR)],
             status_tally[int'(ST_BAD_PTR)]);
    if (errors == 0 && in_flight == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/flptw_pkg.sv
hw/rtl/flptw_if.sv
hw/rtl/flptw_ctrl.sv
hw/rtl/flptw_dp.sv
hw/rtl/four_level_page_table_walker.sv
hw/rtl/flptw_checker.sv
bench/walk_checker.sv
bench/tb_four_level_page_table_walker.sv
